/* rtl/core/wnm_pkg.sv */
// Shared types, character codes and register indexes for the wildcard name matcher.
// No dependencies; imported by every module under rtl/core.
package wnm_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int CHAR_W      = 8;
   localparam int LEN_REG_W   = 6;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_BASE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LEN  = 3'd4;

   localparam logic [CHAR_W-1:0] CHAR_STAR       = 8'h2A;
   localparam logic [CHAR_W-1:0] CHAR_SPACE      = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A    = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z    = 8'h5A;
   localparam logic [CHAR_W-1:0] CASE_OFFSET     = 8'h20;

   // Per-transaction control broadcast to every cell.
   typedef struct packed {
      logic              apply;
      logic              restart;
      logic [CHAR_W-1:0] subj_char;
   } cell_ctl_type;

   // Signals handed from one cell to the next.
   typedef struct packed {
      logic keep;
      logic carry;
      logic match;
      logic spread;
   } cell_link_type;

   function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] r;
      r = c;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

   function automatic logic char_match(input logic [CHAR_W-1:0] p, input logic [CHAR_W-1:0] c);
      logic r;
      if (p == CHAR_SPACE || p == CHAR_UNDERSCORE) begin
         r = (c == CHAR_SPACE) || (c == CHAR_UNDERSCORE);
      end else begin
         r = (fold_case(p) == fold_case(c));
      end
      return r;
   endfunction

endpackage

/* rtl/core/wnm_cell.sv */
// One pattern position of the matcher: holds its reached bit, widens it across '*'
// under the current pattern, advances it on a subject character and widens again.
// Depends on wnm_pkg.
module wnm_cell
   import wnm_pkg::*;
#(
   parameter logic RESET_BIT = 1'b0
) (
   input  logic              clock,
   input  logic              reset,
   input  cell_ctl_type      ctl,
   input  logic [CHAR_W-1:0] pat_char,
   input  logic              active,
   input  cell_link_type     link_in,
   output cell_link_type     link_out,
   output logic              pre_bit,
   output logic              wide_bit
);

   logic state_ff;
   logic state_in;
   logic star;
   logic hit;
   logic pre;
   logic adv;

   assign star = (pat_char == CHAR_STAR);
   assign hit  = char_match(pat_char, ctl.subj_char);

   // Stored bit widened under the pattern as it stands now.
   assign pre = link_in.keep & (state_ff | link_in.spread);

   // A star position keeps its own bit; a matching position passes it right.
   assign adv      = (pre & star & active) | link_in.match;
   assign wide_bit = link_in.keep & (adv | link_in.carry);
   assign state_in = ctl.restart ? RESET_BIT : (ctl.apply ? wide_bit : state_ff);

   assign link_out.keep   = active;
   assign link_out.carry  = wide_bit & star & active;
   assign link_out.match  = pre & active & ~star & hit;
   assign link_out.spread = pre & star & active;

   assign pre_bit = pre;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RESET_BIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/wnm_out_buf.sv */
// Result register with a skid entry so the input side keeps moving while a
// result waits. Depends on wnm_pkg for house conventions only.
module wnm_out_buf
   import wnm_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic in_matched,
   input  logic rsp_stall,
   output logic rsp_valid,
   output logic rsp_matched,
   output logic full
);

   logic out_valid_ff;
   logic out_matched_ff;
   logic skid_valid_ff;
   logic skid_matched_ff;
   logic drain;

   assign drain       = ~out_valid_ff | ~rsp_stall;
   assign rsp_valid   = out_valid_ff;
   assign rsp_matched = out_matched_ff;
   assign full        = skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (drain) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= in_valid;
         end
      end else if (in_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (drain) begin
         out_matched_ff <= skid_valid_ff ? skid_matched_ff : in_matched;
      end
      if (!drain && in_valid) begin
         skid_matched_ff <= in_matched;
      end
   end

endmodule

/* rtl/core/wildcard_name_matcher.sv */
// Wildcard name matcher top level: configuration registers, cell chain, result buffer.
// Depends on wnm_pkg, wnm_cell and wnm_out_buf.
//
// Usage: write the pattern bytes (csr index 0..3, eight bytes each, lowest byte
// first) and the pattern length (index 4) through the csr port while no
// transaction is in flight; a string may be left open across the writes.
// Stream subject bytes on the req channel, one per transaction,
// with req_last_char on the final byte, or one transaction with
// req_empty_subject set for an empty string. Each string end yields one rsp
// transaction whose rsp_matched tells whether the whole string matched.
// Throughput is one subject byte per cycle while req_stall is low; the result is
// registered (in the skid entry if rsp stalls). The rate is set by the reached-bit
// update: the stored bits are widened under the current pattern, advanced on
// the byte and widened again, each pass rippling across one cell per position.
// Register writes never stall the req channel.
// Reset clears the pattern, sets length zero and restarts the position vector.
// When rsp is stalled, one more result is held in a skid entry; req_stall then
// rises until the result register drains.
module wildcard_name_matcher
   import wnm_pkg::*;
#(
   parameter int PATTERN_MAX = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [CHAR_W-1:0]      req_subject_char,
   input  logic                   req_last_char,
   input  logic                   req_empty_subject,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_matched,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);
   localparam int BYTES_PER_REG = CSR_DATA_W / CHAR_W;
   localparam logic [LEN_REG_W-1:0] MAX_LEN = LEN_REG_W'(PATTERN_MAX);

   logic [CHAR_W-1:0]    pat_ff [PATTERN_MAX];
   logic [LEN_REG_W-1:0] pat_len_ff;
   logic [LEN_W-1:0]     len_eff;
   logic                 accept;
   logic                 finish;
   logic                 result_bit;
   logic                 buf_full;
   cell_ctl_type         ctl;
   cell_link_type        links [PATTERN_MAX + 2];
   logic [PATTERN_MAX:0] pre_vec;
   logic [PATTERN_MAX:0] wide_vec;

   assign len_eff = (pat_len_ff > MAX_LEN) ? LEN_W'(PATTERN_MAX) : pat_len_ff[LEN_W-1:0];

   assign req_stall = buf_full;
   assign accept    = req_valid & ~req_stall;
   assign finish    = accept & (req_last_char | req_empty_subject);

   assign ctl.apply     = accept & ~req_empty_subject;
   assign ctl.restart   = finish;
   assign ctl.subj_char = req_subject_char;

   assign links[0] = '{keep: 1'b1, carry: 1'b0, match: 1'b0, spread: 1'b0};

   generate
      for (genvar b = 0; b < PATTERN_MAX; b++) begin : g_pat
         localparam int REG_SEL = b / BYTES_PER_REG;
         localparam int LANE    = b % BYTES_PER_REG;
         always_ff @(posedge clock) begin
            if (reset) begin
               pat_ff[b] <= '0;
            end else if (csr_write_en
                         && csr_index == CSR_PATTERN_BASE + CSR_INDEX_W'(REG_SEL)) begin
               pat_ff[b] <= csr_wdata[LANE*CHAR_W +: CHAR_W];
            end
         end

         wnm_cell #(
            .RESET_BIT (b == 0)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctl      (ctl),
            .pat_char (pat_ff[b]),
            .active   (LEN_W'(b) < len_eff),
            .link_in  (links[b]),
            .link_out (links[b+1]),
            .pre_bit  (pre_vec[b]),
            .wide_bit (wide_vec[b])
         );
      end
   endgenerate

   // Final position: reached means the whole pattern is consumed.
   wnm_cell #(
      .RESET_BIT (1'b0)
   ) u_tail (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .pat_char ('0),
      .active   (1'b0),
      .link_in  (links[PATTERN_MAX]),
      .link_out (links[PATTERN_MAX+1]),
      .pre_bit  (pre_vec[PATTERN_MAX]),
      .wide_bit (wide_vec[PATTERN_MAX])
   );

   assign result_bit = req_empty_subject ? pre_vec[len_eff] : wide_vec[len_eff];

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_len_ff <= '0;
      end else if (csr_write_en && csr_index == CSR_PATTERN_LEN) begin
         pat_len_ff <= csr_wdata[LEN_REG_W-1:0];
      end
   end

   wnm_out_buf u_out_buf (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (finish),
      .in_matched  (result_bit),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_matched (rsp_matched),
      .full        (buf_full)
   );

   a_finish_gives_result: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid)
      else $error("string end did not produce a result");

   a_stalled_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_matched))
      else $error("stalled result changed");

   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      buf_full |-> rsp_valid)
      else $error("skid entry occupied with empty result register");

endmodule
